// ----- sv/emgia_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package emgia_pkg;

  // Widths of the fixed fields.
  localparam int EMG_W    = 10;
  localparam int AXIS_W   = 16;
  localparam int MAG_W    = 17;
  localparam int IDLE_W   = 16;
  localparam int SPASM_W  = 17;
  localparam int SHOWN_W  = 17;
  localparam int COLOR_W  = 2;
  localparam int RGB_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_OFFSET      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPASM_THRESHOLD = 2'd2;

  // Configuration reset values.
  localparam logic [EMG_W-1:0]   ADC_OFFSET_RST      = 10'd512;
  localparam logic [IDLE_W-1:0]  IDLE_THRESHOLD_RST  = 16'd10000;
  localparam logic [SPASM_W-1:0] SPASM_THRESHOLD_RST = 17'd40000;

  // Largest magnitude of one axis and of the three axes together.
  localparam logic [AXIS_W-2:0] AXIS_MAG_MAX = 15'h7FFF;
  localparam int MAG_SUM_MAX = 98301;
  localparam int EMG_MAX     = 1023;

  // Saturation limit of the window_sum field.
  localparam logic [SHOWN_W-1:0] SHOWN_MAX = 17'h1FFFF;

  // Indicator codes and colors.
  localparam logic [COLOR_W-1:0] COLOR_RED    = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_GREEN  = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_ORANGE = 2'd2;
  localparam logic [RGB_W-1:0]   RGB_RED      = 24'hFF0000;
  localparam logic [RGB_W-1:0]   RGB_GREEN    = 24'h00FF00;
  localparam logic [RGB_W-1:0]   RGB_ORANGE   = 24'hFF1500;

  // Pipeline strobes shared by the ring and the motion unit.
  typedef struct packed {
    logic accept;  // a new beat enters the working stage
    logic commit;  // the working stage hands its result to the output register
  } pipe_ctrl_t;

  // Motion unit status toward the output stage.
  typedef struct packed {
    logic alarm_prev;  // latch as it stood before this beat
    logic alarm_next;  // latch after this beat
    logic done;        // this beat closes a motion block
  } motion_status_t;

endpackage

`default_nettype wire

// ----- sv/emg_intensity_and_motion_alarm_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// EMG intensity indicator with motion spasm alarm. One beat per clock is
// accepted. Each beat's result passes from the working stage into the output
// register and is valid on the result side once that register is loaded. The
// accepting edge rectifies the sample and reads its ring entry. The commit
// edge updates the window and block state and loads the output register. The
// full rate of one beat per cycle holds as long as the result side takes its
// beats. The EMG window lives in a WINDOW_LEN-deep memory, and its registered
// read is why the working stage exists. Entries not yet written since reset
// read as zero through a fill mark, so no clearing pass follows reset.
// Configuration writes are always taken (cfg_ready is high) and must only be
// issued while no beat is in flight.
module emg_intensity_and_motion_alarm_core #(
  parameter int WINDOW_LEN = 100,
  parameter int BLOCK_LEN  = 200
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // s_tdata: emg_sample[9:0], accel_x[25:10], accel_y[41:26], accel_z[57:42], zero pad
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire [emgia_pkg::IN_DATA_W-1:0]      s_tdata,
  // m_tdata: rectified[9:0], window_sum[26:10], color_code[28:27],
  // rgb_word[52:29], spasm_alarm[53], block_done[54], zero pad
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [emgia_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [emgia_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [emgia_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import emgia_pkg::*;

  localparam int SUM_W  = $clog2(WINDOW_LEN * EMG_MAX + 1);
  localparam int WIDE_W = (SUM_W > SHOWN_W) ? SUM_W : SHOWN_W;
  localparam int IDLE_CMP_W = (SUM_W > IDLE_W) ? SUM_W : IDLE_W;

  logic [EMG_W-1:0]   adc_offset;
  logic [IDLE_W-1:0]  idle_threshold;
  logic [SPASM_W-1:0] spasm_threshold;

  logic [EMG_W-1:0]  emg;
  logic [EMG_W-1:0]  rect;
  logic [MAG_W-1:0]  mag_sum;
  logic              s1_valid;
  logic [EMG_W-1:0]  s1_rect;
  logic [MAG_W-1:0]  s1_mag;
  pipe_ctrl_t        ctrl;
  motion_status_t    mstat;
  logic [SUM_W-1:0]  sum_next;
  logic [WIDE_W-1:0] sum_wide;
  logic [SHOWN_W-1:0] shown;
  logic [COLOR_W-1:0] color;
  logic [RGB_W-1:0]   rgb;

  // Magnitude of one axis, with the most negative value held at the maximum.
  function automatic logic [AXIS_W-2:0] axis_mag(input logic [AXIS_W-1:0] v);
    logic [AXIS_W-1:0] neg;
    neg = -v;
    if (!v[AXIS_W-1]) begin
      axis_mag = v[AXIS_W-2:0];
    end else if (neg[AXIS_W-1]) begin
      axis_mag = AXIS_MAG_MAX;
    end else begin
      axis_mag = neg[AXIS_W-2:0];
    end
  endfunction

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_offset      <= ADC_OFFSET_RST;
      idle_threshold  <= IDLE_THRESHOLD_RST;
      spasm_threshold <= SPASM_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ADC_OFFSET:      adc_offset      <= cfg_data[EMG_W-1:0];
        CFG_IDLE_THRESHOLD:  idle_threshold  <= cfg_data[IDLE_W-1:0];
        CFG_SPASM_THRESHOLD: spasm_threshold <= cfg_data[SPASM_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the working stage drains into the output register whenever
  // that register is empty or being read.
  assign ctrl.commit = s1_valid && (!m_tvalid || m_tready);
  assign s_tready    = !s1_valid || ctrl.commit;
  assign ctrl.accept = s_tvalid && s_tready;

  // Front stage: rectify and sum the axis magnitudes.
  assign emg  = s_tdata[EMG_W-1:0];
  assign rect = (emg >= adc_offset) ? emg - adc_offset : adc_offset - emg;
  assign mag_sum = MAG_W'(axis_mag(s_tdata[25:10])) + MAG_W'(axis_mag(s_tdata[41:26]))
                 + MAG_W'(axis_mag(s_tdata[57:42]));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ctrl.accept) begin
      s1_valid <= 1'b1;
    end else if (ctrl.commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      s1_rect <= rect;
      s1_mag  <= mag_sum;
    end
  end

  emgia_ring #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .wr_data  (s1_rect),
    .sum_next (sum_next)
  );

  emgia_motion #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_motion (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .mag             (s1_mag),
    .spasm_threshold (spasm_threshold),
    .status          (mstat)
  );

  // Indicator choice uses the latch from before this beat.
  always_comb begin
    if (mstat.alarm_prev) begin
      color = COLOR_RED;
      rgb   = RGB_RED;
    end else if (IDLE_CMP_W'(sum_next) <= IDLE_CMP_W'(idle_threshold)) begin
      color = COLOR_ORANGE;
      rgb   = RGB_ORANGE;
    end else begin
      color = COLOR_GREEN;
      rgb   = RGB_GREEN;
    end
  end

  // The reported window sum saturates at the field width.
  assign sum_wide = WIDE_W'(sum_next);
  assign shown    = (sum_wide > WIDE_W'(SHOWN_MAX)) ? SHOWN_MAX : sum_wide[SHOWN_W-1:0];

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      m_tdata <= {1'b0, mstat.done, mstat.alarm_next, rgb, color, shown, s1_rect};
    end
  end

  // Every committed beat shows up at the output on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |=> m_tvalid)
    else $error("committed beat missing at the output");

  // An accepted beat always occupies the working stage next cycle.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.accept |=> s1_valid)
    else $error("accepted beat lost before the working stage");

endmodule

`default_nettype wire

// ----- sv/emgia_ring.sv -----
`timescale 1ns / 1ps
`default_nettype none

module emgia_ring #(
  parameter int WINDOW_LEN = 100,
  parameter int SUM_W      = 17
) (
  input  wire                           clk,
  input  wire                           rst,
  input  emgia_pkg::pipe_ctrl_t         ctrl,
  input  wire [emgia_pkg::EMG_W-1:0]    wr_data,
  output logic [SUM_W-1:0]              sum_next
);
  import emgia_pkg::*;

  localparam int PTR_W = $clog2(WINDOW_LEN);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);

  logic [EMG_W-1:0] ring_mem [WINDOW_LEN];
  logic [EMG_W-1:0] rd_data;
  logic             rd_valid;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic             filled;
  logic [SUM_W-1:0] running_sum;
  logic [EMG_W-1:0] old_value;

  // Ring memory: the entry of a beat is read when it is accepted and
  // rewritten when it commits. Consecutive beats use different entries.
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      ring_mem[wr_ptr] <= wr_data;
    end
    if (ctrl.accept) begin
      rd_data <= ring_mem[ptr];
      wr_ptr  <= ptr;
    end
  end

  // Write pointer and fill mark. Until the pointer has wrapped once, the
  // entry under it was never written and counts as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      filled   <= 1'b0;
      rd_valid <= 1'b0;
    end else if (ctrl.accept) begin
      rd_valid <= filled;
      if (ptr == PTR_LAST) begin
        ptr    <= '0;
        filled <= 1'b1;
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  // Running sum of the window, exact.
  assign old_value = rd_valid ? rd_data : '0;
  assign sum_next  = running_sum - SUM_W'(old_value) + SUM_W'(wr_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (ctrl.commit) begin
      running_sum <= sum_next;
    end
  end

  // The pointer moves on every accepted beat.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.accept |=> ptr != $past(ptr))
    else $error("ring pointer did not advance");

  // The fill mark is set only as the pointer wraps to the first entry.
  assert property (@(posedge clk) disable iff (rst)
    $rose(filled) |-> ptr == '0)
    else $error("fill mark set away from the wrap");

endmodule

`default_nettype wire

// ----- sv/emgia_motion.sv -----
`timescale 1ns / 1ps
`default_nettype none

module emgia_motion #(
  parameter int BLOCK_LEN = 200
) (
  input  wire                            clk,
  input  wire                            rst,
  input  emgia_pkg::pipe_ctrl_t          ctrl,
  input  wire [emgia_pkg::MAG_W-1:0]     mag,
  input  wire [emgia_pkg::SPASM_W-1:0]   spasm_threshold,
  output emgia_pkg::motion_status_t      status
);
  import emgia_pkg::*;

  localparam int CNT_W = $clog2(BLOCK_LEN);
  localparam int ACC_W = $clog2(BLOCK_LEN * MAG_SUM_MAX + 1);
  localparam int LIM_W = SPASM_W + $clog2(BLOCK_LEN + 1);
  localparam int CMP_W = (ACC_W > LIM_W) ? ACC_W : LIM_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_LEN - 1);

  logic [CNT_W-1:0] block_counter;
  logic [ACC_W-1:0] motion_accumulator;
  logic [ACC_W-1:0] acc_next;
  logic [LIM_W-1:0] spasm_limit;
  logic             alarm_latch;
  logic             block_end;
  logic             over;

  // The truncated mean exceeds the threshold exactly when the block total
  // exceeds threshold * BLOCK_LEN + BLOCK_LEN - 1. The limit is registered
  // from the threshold register.
  always_ff @(posedge clk) begin
    spasm_limit <= LIM_W'(spasm_threshold) * LIM_W'(BLOCK_LEN) + LIM_W'(BLOCK_LEN - 1);
  end

  assign acc_next  = motion_accumulator + ACC_W'(mag);
  assign block_end = (block_counter == CNT_LAST);
  assign over      = CMP_W'(acc_next) > CMP_W'(spasm_limit);

  // Block accumulation and alarm latch.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter      <= '0;
      motion_accumulator <= '0;
      alarm_latch        <= 1'b0;
    end else if (ctrl.commit) begin
      if (block_end) begin
        block_counter      <= '0;
        motion_accumulator <= '0;
        alarm_latch        <= over;
      end else begin
        block_counter      <= block_counter + 1'b1;
        motion_accumulator <= acc_next;
      end
    end
  end

  assign status.alarm_prev = alarm_latch;
  assign status.alarm_next = block_end ? over : alarm_latch;
  assign status.done       = block_end;

  // The counter stays inside one block.
  assert property (@(posedge clk) disable iff (rst)
    block_counter <= CNT_LAST)
    else $error("block counter beyond block length");

  // The latch changes only on a committed block end.
  assert property (@(posedge clk) disable iff (rst)
    !(ctrl.commit && block_end) |=> alarm_latch == $past(alarm_latch))
    else $error("alarm latch changed inside a block");

endmodule

`default_nettype wire
